### hw/rtl/brp_pkg.sv
// Shared types and constants for the ByteRun1 row packer.
// No dependencies; imported by every module of the block but brp_ram.
`default_nettype none
package brp_pkg;
   localparam int STORE_DEPTH      = 128;
   localparam int STORE_AW         = 7;
   localparam int RAM_DEPTH        = 2 * STORE_DEPTH;
   localparam int RAM_AW           = STORE_AW + 1;
   localparam int QUEUE_DEPTH      = 4;
   localparam int MAX_LITERAL_DEF  = 128;
   localparam int MAX_RUN_LEN_DEF  = 128;
   localparam int MIN_RUN_LEN_DEF  = 3;
   localparam int OUT_LANES_DEF    = 8;

   localparam logic KIND_LIT = 1'b0;
   localparam logic KIND_REP = 1'b1;

   // one packet to write: literal (store bank, count) or run (count, value)
   typedef struct packed {
      logic       kind;
      logic [7:0] count;
      logic       bank;
      logic [7:0] value;
      logic       row_end;
   } cmd_type;

   // back end done reading a store bank
   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;
endpackage
`default_nettype wire

### hw/rtl/byterun1_row_packer.sv
// ByteRun1 row packer top level: front end, command queue, back end, literal store.
// Packets: the queued item that closes a packet is popped by the back end, which writes a header,
// then the run value or single literal byte, or each stored literal byte via the store read port.
// Throughput: 1 item per cycle while the queue has room and no store bank is pending;
// while the back end still reads a closed literal from the other bank, no item is taken.
// Reset: synchronous; clears control state, not the back end command/index or the literal store.
`default_nettype none
module byterun1_row_packer #(
   parameter int MAX_LITERAL = brp_pkg::MAX_LITERAL_DEF,
   parameter int MAX_RUN_LEN = brp_pkg::MAX_RUN_LEN_DEF,
   parameter int MIN_RUN_LEN = brp_pkg::MIN_RUN_LEN_DEF,
   parameter int OUT_LANES   = brp_pkg::OUT_LANES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_row_end,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_packed_word,
   output logic [3:0]       rsp_byte_count,
   output logic             rsp_row_last,
   output logic [15:0]      rsp_packed_length
);
   import brp_pkg::*;

   logic              push0_valid, push1_valid, room, head_valid, pop;
   cmd_type           push0_cmd, push1_cmd, head_cmd;
   release_type       release_bank;
   logic              wr_en;
   logic [RAM_AW-1:0] wr_addr, rd_addr;
   logic [7:0]        wr_data, rd_data;

   brp_front #(
      .MAX_LITERAL(MAX_LITERAL),
      .MAX_RUN_LEN(MAX_RUN_LEN),
      .MIN_RUN_LEN(MIN_RUN_LEN)
   ) u_front (
      .clock, .reset,
      .req_valid, .req_ready, .req_data_byte, .req_row_end,
      .push0_valid, .push0_cmd, .push1_valid, .push1_cmd,
      .room, .release_bank,
      .wr_en, .wr_addr, .wr_data
   );

   brp_queue u_queue (
      .clock, .reset,
      .push0_valid, .push0_cmd, .push1_valid, .push1_cmd,
      .room, .head_valid, .head_cmd, .pop
   );

   brp_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_store (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   brp_back #(.OUT_LANES(OUT_LANES)) u_back (
      .clock, .reset,
      .head_valid, .head_cmd, .pop,
      .rd_addr, .rd_data, .release_bank,
      .rsp_valid, .rsp_ready, .rsp_packed_word, .rsp_byte_count,
      .rsp_row_last, .rsp_packed_length
   );
endmodule
`default_nettype wire

### hw/rtl/brp_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module brp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

### hw/rtl/brp_queue.sv
// Command queue between front and back end, two pushes and one pop per cycle.
// Depends on brp_pkg.
`default_nettype none
module brp_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push0_valid,
   input  wire brp_pkg::cmd_type push0_cmd,
   input  wire logic             push1_valid,
   input  wire brp_pkg::cmd_type push1_cmd,
   output logic                  room,
   output logic                  head_valid,
   output brp_pkg::cmd_type      head_cmd,
   input  wire logic             pop
);
   import brp_pkg::*;
   localparam int AW = $clog2(QUEUE_DEPTH);

   cmd_type        entry_ff [QUEUE_DEPTH];
   logic [AW-1:0]  rd_ff, rd_in, wr_ff, wr_in, addr1;
   logic [AW:0]    count_ff, count_in;

   assign addr1      = wr_ff + AW'(push0_valid);
   assign head_valid = count_ff != '0;
   assign head_cmd   = entry_ff[rd_ff];
   assign room       = count_ff <= (AW+1)'(QUEUE_DEPTH - 2);

   always_comb begin
      wr_in    = wr_ff + AW'(push0_valid) + AW'(push1_valid);
      rd_in    = rd_ff + AW'(pop);
      count_in = count_ff + (AW+1)'(push0_valid) + (AW+1)'(push1_valid) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push0_valid) begin
         entry_ff[wr_ff] <= push0_cmd;
      end
      if (push1_valid) begin
         entry_ff[addr1] <= push1_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff    <= '0;
         wr_ff    <= '0;
         count_ff <= '0;
      end else begin
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         count_ff <= count_in;
      end
   end
endmodule
`default_nettype wire

### hw/rtl/brp_front.sv
// Front end: takes raw bytes, fills the literal store, tracks runs and queues packets.
// Depends on brp_pkg.
`default_nettype none
module brp_front #(
   parameter int MAX_LITERAL = brp_pkg::MAX_LITERAL_DEF,
   parameter int MAX_RUN_LEN = brp_pkg::MAX_RUN_LEN_DEF,
   parameter int MIN_RUN_LEN = brp_pkg::MIN_RUN_LEN_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [7:0]               req_data_byte,
   input  wire logic                     req_row_end,
   output logic                          push0_valid,
   output brp_pkg::cmd_type              push0_cmd,
   output logic                          push1_valid,
   output brp_pkg::cmd_type              push1_cmd,
   input  wire logic                     room,
   input  wire brp_pkg::release_type     release_bank,
   output logic                          wr_en,
   output logic [brp_pkg::RAM_AW-1:0]    wr_addr,
   output logic [7:0]                    wr_data
);
   import brp_pkg::*;

   logic       started_ff, started_in;
   logic       mode_ff, mode_in;
   logic [8:0] fill_ff, fill_in;
   logic [7:0] rs_ff, rs_in;
   logic [7:0] prev_ff, prev_in;
   logic [7:0] first_ff, first_in;
   logic       bank_ff, bank_in;
   logic [1:0] busy_ff, busy_in, busy_set, busy_clr;
   logic       accept;
   logic [7:0] c;

   assign c         = req_data_byte;
   assign req_ready = room && !busy_ff[~bank_ff];
   assign accept    = req_valid && req_ready;
   assign wr_data   = c;
   assign busy_clr  = release_bank.valid ? (2'b01 << release_bank.bank) : 2'b00;
   assign busy_in   = (busy_ff & ~busy_clr) | busy_set;

   always_comb begin
      started_in  = started_ff;
      mode_in     = mode_ff;
      fill_in     = fill_ff;
      rs_in       = rs_ff;
      prev_in     = prev_ff;
      first_in    = first_ff;
      bank_in     = bank_ff;
      busy_set    = 2'b00;
      push0_valid = 1'b0;
      push0_cmd   = '0;
      push1_valid = 1'b0;
      push1_cmd   = '0;
      wr_en       = 1'b0;
      wr_addr     = {bank_ff, STORE_AW'(0)};
      if (accept) begin
         prev_in = c;
         if (!started_ff) begin
            wr_en      = 1'b1;
            first_in   = c;
            fill_in    = 9'd1;
            rs_in      = '0;
            mode_in    = 1'b0;
            started_in = 1'b1;
         end else begin
            if (fill_ff < 9'(STORE_DEPTH)) begin
               wr_en   = 1'b1;
               wr_addr = {bank_ff, fill_ff[STORE_AW-1:0]};
            end
            fill_in = fill_ff + 9'd1;
            if (!mode_ff) begin
               if (fill_in > 9'(MAX_LITERAL)) begin
                  push0_valid = 1'b1;
                  push0_cmd   = '{kind: KIND_LIT, count: fill_ff[7:0], bank: bank_ff,
                                  value: first_ff, row_end: 1'b0};
                  if (fill_ff > 9'd1) begin
                     busy_set[bank_ff] = 1'b1;
                     bank_in           = ~bank_ff;
                  end
                  wr_en    = 1'b1;
                  wr_addr  = {bank_in, STORE_AW'(0)};
                  first_in = c;
                  fill_in  = 9'd1;
                  rs_in    = '0;
               end else if (c == prev_ff) begin
                  if (fill_in - {1'b0, rs_ff} >= 9'(MIN_RUN_LEN)) begin
                     if (rs_ff != '0) begin
                        push0_valid = 1'b1;
                        push0_cmd   = '{kind: KIND_LIT, count: rs_ff, bank: bank_ff,
                                        value: first_ff, row_end: 1'b0};
                        if (rs_ff > 8'd1) begin
                           busy_set[bank_ff] = 1'b1;
                           bank_in           = ~bank_ff;
                        end
                        fill_in = fill_in - {1'b0, rs_ff};
                        rs_in   = '0;
                     end
                     mode_in = 1'b1;
                  end else if (rs_ff == '0) begin
                     mode_in = 1'b1;
                  end
               end else begin
                  rs_in = fill_ff[7:0];
               end
            end else begin
               if (c != prev_ff || fill_in - {1'b0, rs_ff} > 9'(MAX_RUN_LEN)) begin
                  push0_valid = 1'b1;
                  push0_cmd   = '{kind: KIND_REP, count: 8'(fill_ff - {1'b0, rs_ff}),
                                  bank: bank_ff, value: prev_ff, row_end: 1'b0};
                  wr_en    = 1'b1;
                  wr_addr  = {bank_ff, STORE_AW'(0)};
                  first_in = c;
                  fill_in  = 9'd1;
                  rs_in    = '0;
                  mode_in  = 1'b0;
               end
            end
         end
         if (req_row_end) begin
            push1_valid = 1'b1;
            if (mode_in) begin
               push1_cmd = '{kind: KIND_REP, count: 8'(fill_in - {1'b0, rs_in}),
                             bank: bank_in, value: prev_in, row_end: 1'b1};
            end else begin
               push1_cmd = '{kind: KIND_LIT, count: fill_in[7:0], bank: bank_in,
                             value: first_in, row_end: 1'b1};
               if (fill_in > 9'd1) begin
                  busy_set[bank_in] = 1'b1;
                  bank_in           = ~bank_in;
               end
            end
            started_in = 1'b0;
            fill_in    = '0;
            rs_in      = '0;
            mode_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         mode_ff    <= 1'b0;
         fill_ff    <= '0;
         rs_ff      <= '0;
         prev_ff    <= '0;
         first_ff   <= '0;
         bank_ff    <= 1'b0;
         busy_ff    <= 2'b00;
      end else begin
         started_ff <= started_in;
         mode_ff    <= mode_in;
         fill_ff    <= fill_in;
         rs_ff      <= rs_in;
         prev_ff    <= prev_in;
         first_ff   <= first_in;
         bank_ff    <= bank_in;
         busy_ff    <= busy_in;
      end
   end
endmodule
`default_nettype wire

### hw/rtl/brp_back.sv
// Back end: writes queued packets byte by byte into output words.
// Depends on brp_pkg; reads the literal store through the RAM read port.
`default_nettype none
module brp_back #(
   parameter int OUT_LANES = brp_pkg::OUT_LANES_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     head_valid,
   input  wire brp_pkg::cmd_type         head_cmd,
   output logic                          pop,
   output logic [brp_pkg::RAM_AW-1:0]    rd_addr,
   input  wire logic [7:0]               rd_data,
   output brp_pkg::release_type          release_bank,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [63:0]                   rsp_packed_word,
   output logic [3:0]                    rsp_byte_count,
   output logic                          rsp_row_last,
   output logic [15:0]                   rsp_packed_length
);
   import brp_pkg::*;
   localparam int FW = $clog2(OUT_LANES + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_HDR  = 3'd1;
   localparam logic [2:0] ST_RD   = 3'd2;
   localparam logic [2:0] ST_DAT  = 3'd3;
   localparam logic [2:0] ST_VAL  = 3'd4;

   logic [2:0]    state_ff, state_in;
   cmd_type       cmd_ff, cmd_in;
   logic [7:0]    idx_ff, idx_in;
   logic [63:0]   stage_ff, stage_in, word;
   logic [FW-1:0] sfill_ff, sfill_in, nfill;
   logic [15:0]   len_ff, len_in, len_inc;
   logic          ovalid_ff, ovalid_in;
   logic [63:0]   oword_ff, oword_in;
   logic [3:0]    ocount_ff, ocount_in;
   logic          olast_ff, olast_in;
   logic [15:0]   olen_ff, olen_in;
   logic          can_put, put, plast, emit, rlast;
   logic [7:0]    pbyte;

   assign can_put           = !ovalid_ff || rsp_ready;
   assign rd_addr           = {cmd_ff.bank, idx_ff[STORE_AW-1:0]};
   assign rsp_valid         = ovalid_ff;
   assign rsp_packed_word   = oword_ff;
   assign rsp_byte_count    = ocount_ff;
   assign rsp_row_last      = olast_ff;
   assign rsp_packed_length = olen_ff;
   assign word    = stage_ff | (64'(pbyte) << {sfill_ff, 3'b000});
   assign nfill   = sfill_ff + FW'(1);
   assign len_inc = (len_ff == 16'hFFFF) ? len_ff : len_ff + 16'd1;
   assign rlast   = plast && cmd_ff.row_end;
   assign emit    = put && (nfill == FW'(OUT_LANES) || rlast);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      pop          = 1'b0;
      put          = 1'b0;
      plast        = 1'b0;
      pbyte        = cmd_ff.value;
      release_bank = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop      = 1'b1;
               cmd_in   = head_cmd;
               idx_in   = '0;
               state_in = ST_HDR;
            end
         end
         ST_HDR: begin
            pbyte = (cmd_ff.kind == KIND_LIT) ? cmd_ff.count - 8'd1
                                              : 8'(9'd257 - {1'b0, cmd_ff.count});
            if (can_put) begin
               put      = 1'b1;
               state_in = (cmd_ff.kind == KIND_REP || cmd_ff.count == 8'd1) ? ST_VAL : ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_DAT;
         end
         ST_DAT: begin
            pbyte = rd_data;
            if (can_put) begin
               put    = 1'b1;
               idx_in = idx_ff + 8'd1;
               if (idx_ff == cmd_ff.count - 8'd1) begin
                  plast              = 1'b1;
                  release_bank.valid = 1'b1;
                  release_bank.bank  = cmd_ff.bank;
                  state_in           = ST_IDLE;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_VAL: begin
            if (can_put) begin
               put      = 1'b1;
               plast    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      stage_in  = stage_ff;
      sfill_in  = sfill_ff;
      len_in    = len_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      oword_in  = oword_ff;
      ocount_in = ocount_ff;
      olast_in  = olast_ff;
      olen_in   = olen_ff;
      if (put) begin
         if (emit) begin
            ovalid_in = 1'b1;
            oword_in  = word;
            ocount_in = 4'(nfill);
            olast_in  = rlast;
            olen_in   = rlast ? len_inc : 16'd0;
            stage_in  = '0;
            sfill_in  = '0;
            len_in    = rlast ? 16'd0 : len_inc;
         end else begin
            stage_in = word;
            sfill_in = nfill;
            len_in   = len_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      idx_ff    <= idx_in;
      oword_ff  <= oword_in;
      ocount_ff <= ocount_in;
      olast_ff  <= olast_in;
      olen_ff   <= olen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         stage_ff  <= '0;
         sfill_ff  <= '0;
         len_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         stage_ff  <= stage_in;
         sfill_ff  <= sfill_in;
         len_ff    <= len_in;
         ovalid_ff <= ovalid_in;
      end
   end
endmodule
`default_nettype wire
